### design/sa_chk_pkg.sv
package sa_chk_pkg;

  localparam int MAX_TEXT = 1024;
  localparam int SYMBOLS  = 62;
  localparam int NODES    = 2 * MAX_TEXT + 1;
  localparam int NODE_W   = $clog2(NODES);
  localparam int LEN_W    = $clog2(MAX_TEXT + 1);
  localparam int SYM_W    = 6;
  localparam int ROW      = 1 << SYM_W;
  localparam int TADDR_W  = NODE_W + SYM_W;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] character;
    logic       first_of_query;
    logic       last_of_query;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic overflow;
  } res_t;

  typedef struct packed {
    logic             ok;
    logic [SYM_W-1:0] sym;
  } sym_t;

  function automatic sym_t symbol_of(input logic [7:0] b);
    sym_t r;
    r.ok  = 1'b1;
    r.sym = '0;
    if (b >= 8'h61 && b <= 8'h7a) begin
      r.sym = SYM_W'(b - 8'h61);
    end else if (b >= 8'h41 && b <= 8'h5a) begin
      r.sym = SYM_W'(b - 8'h41 + 8'd26);
    end else if (b >= 8'h30 && b <= 8'h39) begin
      r.sym = SYM_W'(b - 8'h30 + 8'd52);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

### design/suffix_automaton_substring_check.sv
// Channel   Ports                          Transfer
// command   start, busy, command           start && !busy
// result    result_valid, result           result_valid (one cycle, no stall)
//
// Query byte: uses S_QRY when it reads the transition memory, else only S_IDLE.
// Append: clears the new row (S_CLR), then walks suffix links (S_WRD, S_WCHK,
// S_WLNK per step); an existing edge adds length reads (S_LENP, S_LENQ), a clone
// link writes (S_LNKQ, S_LNK2, S_LNK3), a row copy (S_COPY) and redirect steps
// (S_RRD, S_RCHK, S_RLNK), as the transition memory has a single read port.
// Reset and clear run the root row clearing pass (S_CLRRT), busy high meanwhile.
// The receiver cannot stall: a result stands for exactly one cycle.
module suffix_automaton_substring_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sa_chk_pkg::cmd_t  command,
  output logic              result_valid,
  output sa_chk_pkg::res_t  result
);

  localparam int NW = sa_chk_pkg::NODE_W;
  localparam int LW = sa_chk_pkg::LEN_W;
  localparam int SW = sa_chk_pkg::SYM_W;
  localparam int AW = sa_chk_pkg::TADDR_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLRRT  = 4'd1;
  localparam logic [3:0] S_CLR    = 4'd2;
  localparam logic [3:0] S_WRD    = 4'd3;
  localparam logic [3:0] S_WCHK   = 4'd4;
  localparam logic [3:0] S_WLNK   = 4'd5;
  localparam logic [3:0] S_LENP   = 4'd6;
  localparam logic [3:0] S_LENQ   = 4'd7;
  localparam logic [3:0] S_LNKQ   = 4'd8;
  localparam logic [3:0] S_LNK2   = 4'd9;
  localparam logic [3:0] S_LNK3   = 4'd10;
  localparam logic [3:0] S_COPY   = 4'd11;
  localparam logic [3:0] S_RRD    = 4'd12;
  localparam logic [3:0] S_RCHK   = 4'd13;
  localparam logic [3:0] S_RLNK   = 4'd14;
  localparam logic [3:0] S_QRY    = 4'd15;

  logic [NW-1:0] trans [sa_chk_pkg::NODES * sa_chk_pkg::ROW];
  logic [NW-1:0] link  [sa_chk_pkg::NODES];
  logic [LW-1:0] len   [sa_chk_pkg::NODES];

  logic [3:0]    state;
  logic [NW-1:0] p, q, cur, cl, last_node, cursor;
  logic [NW:0]   next_free;
  logic [LW-1:0] last_len, lenp;
  logic [SW-1:0] sym;
  logic [SW:0]   cnt;
  logic          alive, overflow, qlast;

  logic [AW-1:0] tr_addr, tw_addr;
  logic [NW-1:0] tw_data, tr_q, lk_q, lk_addr, lk_waddr, lk_wdata;
  logic [NW-1:0] ln_addr, ln_waddr;
  logic [LW-1:0] ln_q, ln_wdata;
  logic          tw_en, lk_we, ln_we;

  sa_chk_pkg::sym_t in_sym;
  logic             accept;
  logic [NW-1:0]    q_cur;
  logic             q_alive;
  logic             result_valid_next;

  assign in_sym  = sa_chk_pkg::symbol_of(command.character);
  assign accept  = start && !busy;
  assign busy    = (state != S_IDLE);
  assign q_cur   = command.first_of_query ? '0 : cursor;
  assign q_alive = command.first_of_query ? 1'b1 : alive;

  always_comb begin
    unique case (state)
      S_IDLE:  tr_addr = {q_cur, in_sym.sym};
      S_COPY:  tr_addr = {q, cnt[SW-1:0]};
      default: tr_addr = {p, sym};
    endcase
    lk_addr = (state == S_LENQ) ? q : p;
    ln_addr = (state == S_LENP) ? q : p;
  end

  always_ff @(posedge clk) begin
    if (tw_en) begin
      trans[tw_addr] <= tw_data;
    end
    tr_q <= trans[tr_addr];
    if (lk_we) begin
      link[lk_waddr] <= lk_wdata;
    end
    lk_q <= link[lk_addr];
    if (ln_we) begin
      len[ln_waddr] <= ln_wdata;
    end
    ln_q <= len[ln_addr];
  end

  // memory write ports
  always_comb begin
    tw_en    = 1'b0;
    tw_addr  = {p, sym};
    tw_data  = cur;
    lk_we    = 1'b0;
    lk_waddr = cur;
    lk_wdata = '0;
    ln_we    = 1'b0;
    ln_waddr = cur;
    ln_wdata = LW'(last_len + 1'b1);
    unique case (state)
      S_IDLE: begin
        if (accept && command.operation == sa_chk_pkg::OP_APPEND && in_sym.ok &&
            last_len < LW'(sa_chk_pkg::MAX_TEXT) &&
            32'(next_free) + 32'd2 <= 32'(sa_chk_pkg::NODES)) begin
          ln_we    = 1'b1;
          ln_waddr = next_free[NW-1:0];
          lk_we    = 1'b1;
          lk_waddr = next_free[NW-1:0];
        end
      end
      S_CLRRT: begin
        tw_en    = 1'b1;
        tw_addr  = {{NW{1'b0}}, cnt[SW-1:0]};
        tw_data  = '0;
        ln_we    = 1'b1;
        ln_waddr = '0;
        ln_wdata = '0;
      end
      S_CLR: begin
        tw_en   = 1'b1;
        tw_addr = {cur, cnt[SW-1:0]};
        tw_data = '0;
      end
      S_WCHK: begin
        tw_en = (tr_q == '0);
      end
      S_LENQ: begin
        if (LW'(lenp + 1'b1) == ln_q) begin
          lk_we    = 1'b1;
          lk_wdata = q;
        end else begin
          ln_we    = 1'b1;
          ln_waddr = next_free[NW-1:0];
          ln_wdata = LW'(lenp + 1'b1);
        end
      end
      S_LNKQ: begin
        lk_we    = 1'b1;
        lk_waddr = cl;
        lk_wdata = lk_q;
      end
      S_LNK2: begin
        lk_we    = 1'b1;
        lk_waddr = q;
        lk_wdata = cl;
      end
      S_LNK3: begin
        lk_we    = 1'b1;
        lk_wdata = cl;
      end
      S_COPY: begin
        // read runs one entry ahead of the write
        tw_en   = (cnt != '0);
        tw_addr = {cl, SW'(cnt - 1'b1)};
        tw_data = tr_q;
      end
      S_RCHK: begin
        tw_en   = (tr_q == q);
        tw_data = cl;
      end
      default: ;
    endcase
  end

  // a query byte that skips the memory read answers straight away
  always_comb begin
    result_valid_next = 1'b0;
    if (state == S_QRY) begin
      result_valid_next = qlast;
    end else if (accept && command.operation == sa_chk_pkg::OP_QUERY &&
                 !(q_alive && in_sym.ok)) begin
      result_valid_next = command.last_of_query;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLRRT;
      cnt       <= '0;
      last_node <= '0;
      last_len  <= '0;
      next_free <= (NW+1)'(1);
      cursor    <= '0;
      alive     <= 1'b1;
      overflow  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority case (command.operation)
              sa_chk_pkg::OP_CLEAR: begin
                state     <= S_CLRRT;
                cnt       <= '0;
                last_node <= '0;
                last_len  <= '0;
                next_free <= (NW+1)'(1);
                cursor    <= '0;
                alive     <= 1'b1;
                overflow  <= 1'b0;
              end
              sa_chk_pkg::OP_APPEND: begin
                if (tw_en || ln_we) begin
                  cur       <= next_free[NW-1:0];
                  p         <= last_node;
                  sym       <= in_sym.sym;
                  last_node <= next_free[NW-1:0];
                  last_len  <= LW'(last_len + 1'b1);
                  next_free <= (NW+1)'(next_free + 1'b1);
                  cnt       <= '0;
                  state     <= S_CLR;
                end else begin
                  overflow <= 1'b1;
                end
              end
              sa_chk_pkg::OP_QUERY: begin
                qlast <= command.last_of_query;
                if (q_alive && in_sym.ok) begin
                  cursor <= q_cur;
                  alive  <= 1'b1;
                  state  <= S_QRY;
                end else if (command.last_of_query) begin
                  result.found    <= 1'b0;
                  result.overflow <= overflow;
                  cursor          <= '0;
                  alive           <= 1'b1;
                end else begin
                  cursor <= q_cur;
                  alive  <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_QRY: begin
          state <= S_IDLE;
          if (qlast) begin
            result.found    <= (tr_q != '0);
            result.overflow <= overflow;
            cursor          <= '0;
            alive           <= 1'b1;
          end else if (tr_q == '0) begin
            alive <= 1'b0;
          end else begin
            cursor <= tr_q;
          end
        end
        S_CLRRT, S_CLR: begin
          cnt <= (SW+1)'(cnt + 1'b1);
          if (cnt == (SW+1)'(sa_chk_pkg::SYMBOLS - 1)) begin
            state <= (state == S_CLR) ? S_WRD : S_IDLE;
          end
        end
        S_WRD: state <= S_WCHK;
        S_WCHK: begin
          if (tr_q == '0) begin
            state <= (p == '0) ? S_IDLE : S_WLNK;
          end else begin
            q     <= tr_q;
            state <= S_LENP;
          end
        end
        S_WLNK: begin
          p     <= lk_q;
          state <= S_WRD;
        end
        S_LENP: begin
          lenp  <= ln_q;
          state <= S_LENQ;
        end
        S_LENQ: begin
          if (LW'(lenp + 1'b1) == ln_q) begin
            state <= S_IDLE;
          end else begin
            cl        <= next_free[NW-1:0];
            next_free <= (NW+1)'(next_free + 1'b1);
            state     <= S_LNKQ;
          end
        end
        S_LNKQ: state <= S_LNK2;
        S_LNK2: state <= S_LNK3;
        S_LNK3: begin
          cnt   <= '0;
          state <= S_COPY;
        end
        S_COPY: begin
          cnt <= (SW+1)'(cnt + 1'b1);
          if (cnt == (SW+1)'(sa_chk_pkg::SYMBOLS)) begin
            state <= S_RRD;
          end
        end
        S_RRD: state <= S_RCHK;
        S_RCHK: begin
          if (tr_q == q && p != '0) begin
            state <= S_RLNK;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RLNK: begin
          p     <= lk_q;
          state <= S_RRD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_res_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_QRY || (start && state == S_IDLE)))
    else $error("result without a query transfer");

  a_rst_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy clearing after reset");

  a_idle_nowr: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !tw_en)
    else $error("transition write while idle");

endmodule

### tb/tb_suffix_automaton_substring_check.sv
`timescale 1ns / 1ps

module tb_suffix_automaton_substring_check;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int NNODES      = 2 * sa_chk_pkg::MAX_TEXT + 1;
  localparam int NSYM        = sa_chk_pkg::SYMBOLS;

  class substring_scoreboard;
    int unsigned trans[NNODES * NSYM];
    int unsigned link[NNODES];
    int unsigned len[NNODES];
    int unsigned last_n, free_n, cursor;
    bit alive, ovf;
    sa_chk_pkg::res_t verdict_q[$];
    int errors, answers;

    function new();
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < NSYM; i++) trans[i] = 0;
      len[0] = 0;
      link[0] = 0;
      last_n = 0;
      free_n = 1;
      cursor = 0;
      alive = 1;
      ovf = 0;
    endfunction

    function int sym_code(logic [7:0] b);
      if (b >= "a" && b <= "z") return b - "a";
      if (b >= "A" && b <= "Z") return b - "A" + 26;
      if (b >= "0" && b <= "9") return b - "0" + 52;
      return -1;
    endfunction

    function int unsigned alloc(int unsigned l);
      int unsigned n;
      n = free_n++;
      for (int i = 0; i < NSYM; i++) trans[n * NSYM + i] = 0;
      len[n] = l;
      link[n] = 0;
      return n;
    endfunction

    function void extend(int unsigned s);
      int unsigned p, cur, q, cl;
      bit have;
      p = last_n;
      cur = alloc(len[p] + 1);
      have = 1;
      while (have && trans[p * NSYM + s] == 0) begin
        trans[p * NSYM + s] = cur;
        if (p == 0) have = 0; else p = link[p];
      end
      if (!have) begin
        link[cur] = 0;
      end else begin
        q = trans[p * NSYM + s];
        if (len[p] + 1 == len[q]) begin
          link[cur] = q;
        end else begin
          // split q: clone takes the shorter length
          cl = alloc(len[p] + 1);
          for (int i = 0; i < NSYM; i++) trans[cl * NSYM + i] = trans[q * NSYM + i];
          link[cl] = link[q];
          link[q] = cl;
          link[cur] = cl;
          while (have && trans[p * NSYM + s] == q) begin
            trans[p * NSYM + s] = cl;
            if (p == 0) have = 0; else p = link[p];
          end
        end
      end
      last_n = cur;
    endfunction

    function void note(sa_chk_pkg::cmd_t c);
      int s;
      int unsigned nx;
      sa_chk_pkg::res_t r;
      s = sym_code(c.character);
      case (c.operation)
        sa_chk_pkg::OP_CLEAR: restart();
        sa_chk_pkg::OP_APPEND: begin
          if (s < 0 || len[last_n] >= sa_chk_pkg::MAX_TEXT || free_n + 2 > NNODES) ovf = 1;
          else extend(s);
        end
        sa_chk_pkg::OP_QUERY: begin
          if (c.first_of_query) begin
            cursor = 0;
            alive = 1;
          end
          if (alive) begin
            nx = (s >= 0) ? trans[cursor * NSYM + s] : 0;
            if (nx == 0) alive = 0; else cursor = nx;
          end
          if (c.last_of_query) begin
            r.found = alive;
            r.overflow = ovf;
            verdict_q.push_back(r);
            cursor = 0;
            alive = 1;
          end
        end
        default: ;
      endcase
    endfunction

    function void check(sa_chk_pkg::res_t r);
      sa_chk_pkg::res_t e;
      if (verdict_q.size() == 0) begin
        $error("unexpected result found=%0b overflow=%0b", r.found, r.overflow);
        errors++;
        return;
      end
      e = verdict_q.pop_front();
      answers++;
      if (r.found !== e.found) begin
        $error("found: expected %0b, got %0b", e.found, r.found);
        errors++;
      end
      if (r.overflow !== e.overflow) begin
        $error("overflow: expected %0b, got %0b", e.overflow, r.overflow);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  sa_chk_pkg::cmd_t command = '0;
  logic result_valid;
  sa_chk_pkg::res_t result;

  substring_scoreboard sb;
  int cycles = 0;
  int idle_pct = 0;
  int sent = 0;
  int found_hits = 0;
  logic [7:0] text_q[$];

  suffix_automaton_substring_check u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .result_valid(result_valid), .result(result)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (result.found) found_hits++;
      sb.check(result);
    end
  end

  task automatic send(logic [1:0] op, logic [7:0] ch, bit fq, bit lq);
    command <= '{operation: op, character: ch, first_of_query: fq, last_of_query: lq};
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note('{operation: op, character: ch, first_of_query: fq, last_of_query: lq});
    sent++;
    if (op == sa_chk_pkg::OP_CLEAR) text_q.delete();
    if (op == sa_chk_pkg::OP_APPEND && sb.sym_code(ch) >= 0 &&
        text_q.size() < sa_chk_pkg::MAX_TEXT)
      text_q.push_back(ch);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_char(int mode);
    int v;
    case (mode)
      0: return $urandom_range(0, 1) ? "b" : "a";
      1: return 8'("a" + $urandom_range(0, 3));
      default: begin
        v = $urandom_range(0, 61);
        if (v < 26) return 8'("a" + v);
        if (v < 52) return 8'("A" + v - 26);
        return 8'("0" + v - 52);
      end
    endcase
  endfunction

  task automatic query_seq(int mode);
    int n, st;
    bit from_text;
    logic [7:0] ch;
    from_text = text_q.size() > 0 && $urandom_range(0, 9) < 7;
    n = $urandom_range(1, 8);
    st = 0;
    if (from_text) begin
      st = $urandom_range(0, text_q.size() - 1);
      if (n > text_q.size() - st) n = text_q.size() - st;
    end
    for (int i = 0; i < n; i++) begin
      ch = from_text ? text_q[st + i] : pick_char(mode);
      if ($urandom_range(0, 29) == 0) ch = 8'($urandom_range(0, 255));
      // occasional text byte slipped into an open query
      if (i > 0 && $urandom_range(0, 19) == 0)
        send(sa_chk_pkg::OP_APPEND, pick_char(mode), 1'b0, 1'b0);
      send(sa_chk_pkg::OP_QUERY, ch, (i == 0) ? ($urandom_range(0, 9) != 0) : 1'b0,
           i == n - 1);
    end
  endtask

  task automatic random_phase(int target);
    int mode, stop_at;
    stop_at = sent + target;
    while (sent < stop_at) begin
      mode = $urandom_range(0, 2);
      case ($urandom_range(0, 19))
        0: send(sa_chk_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom),
                1'($urandom));
        1, 2: send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'($urandom),
                   1'($urandom));
        3, 4, 5, 6, 7, 8:
          repeat ($urandom_range(1, 12))
            send(sa_chk_pkg::OP_APPEND, pick_char(mode), 1'($urandom), 1'($urandom));
        default: query_seq(mode);
      endcase
    end
  endtask

  initial begin
    string dir_txt;
    sb = new();
    dir_txt = "azAZ09";
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, every op, dropped bytes, broken queries
    send(sa_chk_pkg::OP_CLEAR, 8'hff, 1, 1);
    for (int i = 0; i < dir_txt.len(); i++) send(sa_chk_pkg::OP_APPEND, dir_txt[i], 1, 1);
    send(sa_chk_pkg::OP_APPEND, 8'h00, 0, 0);
    send(sa_chk_pkg::OP_QUERY, "z", 1, 0);
    send(sa_chk_pkg::OP_QUERY, "A", 0, 1);
    send(sa_chk_pkg::OP_QUERY, "Z", 1, 0);
    send(sa_chk_pkg::OP_QUERY, "9", 0, 1);
    send(sa_chk_pkg::OP_QUERY, "~", 1, 1);
    send(sa_chk_pkg::OP_QUERY, "9", 0, 1);
    send(sa_chk_pkg::OP_QUERY, "a", 1, 0);
    send(sa_chk_pkg::OP_QUERY, 8'hff, 0, 1);
    send(2'd3, 8'hff, 1, 1);
    send(sa_chk_pkg::OP_CLEAR, 8'h00, 0, 0);
    send(sa_chk_pkg::OP_QUERY, "a", 1, 1);
    send(sa_chk_pkg::OP_APPEND, "a", 0, 0);
    send(sa_chk_pkg::OP_APPEND, "b", 0, 0);
    send(sa_chk_pkg::OP_APPEND, "a", 0, 0);
    send(sa_chk_pkg::OP_QUERY, "b", 1, 0);
    send(sa_chk_pkg::OP_QUERY, "a", 0, 1);

    idle_pct = 7;
    random_phase(210);
    idle_pct = 46;
    random_phase(210);
    idle_pct = 0;
    random_phase(210);

    repeat (20) query_seq(2);

    start <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("%0d commands sent, %0d query verdicts checked (%0d found)",
             sent, sb.answers, found_hits);
    $display("covered clears, dropped bytes, clones, broken queries and three pacing modes");
    if (sb.errors == 0 && sb.verdict_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
design/sa_chk_pkg.sv
design/suffix_automaton_substring_check.sv
tb/tb_suffix_automaton_substring_check.sv
